FILE: rtl/lkp_pkg.sv
// Shared constants, types and character helpers for the location keyword parser.
package lkp_pkg;

  localparam int NUMBER_WIDTH_DEF = 32;
  localparam int OUT_W = 32;

  localparam logic [7:0] CASE_OFFSET = 8'h20;
  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_COLON    = ":";
  localparam logic [7:0] CH_0        = "0";
  localparam logic [7:0] CH_7        = "7";
  localparam logic [7:0] CH_9        = "9";
  localparam logic [7:0] CH_A        = "A";
  localparam logic [7:0] CH_B        = "B";
  localparam logic [7:0] CH_C        = "C";
  localparam logic [7:0] CH_D        = "D";
  localparam logic [7:0] CH_E        = "E";
  localparam logic [7:0] CH_F        = "F";
  localparam logic [7:0] CH_G        = "G";
  localparam logic [7:0] CH_N        = "N";
  localparam logic [7:0] CH_R        = "R";
  localparam logic [7:0] CH_S        = "S";
  localparam logic [7:0] CH_U        = "U";
  localparam logic [7:0] CH_V        = "V";
  localparam logic [7:0] CH_X        = "X";
  localparam logic [7:0] CH_LOW_A    = "a";
  localparam logic [7:0] CH_LOW_Z    = "z";

  localparam logic [4:0] HEX_NONE = 5'd16;

  typedef enum logic [1:0] {
    RADIX_DEC,
    RADIX_OCT,
    RADIX_HEX
  } radix_t;

  typedef struct packed {
    logic             emit;
    logic             ok;
    logic [OUT_W-1:0] device_value;
    logic [OUT_W-1:0] function_value;
    logic [OUT_W-1:0] bus_value;
    logic [OUT_W-1:0] register_value;
  } lkp_result_t;

  function automatic logic [7:0] upcase(input logic [7:0] c);
    logic [7:0] u;
    u = c;
    if (c inside {[CH_LOW_A:CH_LOW_Z]}) u = c - CASE_OFFSET;
    return u;
  endfunction

  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = HEX_NONE;
    if (c inside {[CH_0:CH_9]}) v = 5'(c - CH_0);
    else if (c inside {[CH_A:CH_F]}) v = 5'(c - CH_A + 8'd10);
    return v;
  endfunction

endpackage

FILE: rtl/lkp_accum.sv
// Digit check and saturating multiply-accumulate for one number character.
module lkp_accum #(
  parameter int NUMBER_WIDTH = lkp_pkg::NUMBER_WIDTH_DEF
) (
  input  logic [7:0]              c,
  input  lkp_pkg::radix_t         radix,
  input  logic [NUMBER_WIDTH-1:0] acc,
  output logic                    digit_ok,
  output logic [NUMBER_WIDTH-1:0] acc_next
);
  import lkp_pkg::*;

  localparam int WW = NUMBER_WIDTH + 5;

  logic [4:0]    hv;
  logic [WW-1:0] scaled;
  logic [WW-1:0] wide;

  always_comb begin
    hv = hex_value(c);
    case (radix)
      RADIX_HEX: begin
        digit_ok = !hv[4];
        scaled   = WW'(acc) << 4;
      end
      RADIX_OCT: begin
        digit_ok = (hv < 5'd8);
        scaled   = WW'(acc) << 3;
      end
      default: begin
        digit_ok = (hv < 5'd10);
        scaled   = (WW'(acc) << 3) + (WW'(acc) << 1);
      end
    endcase
    wide     = scaled + WW'(hv[3:0]);
    acc_next = (|wide[WW-1:NUMBER_WIDTH]) ? '1 : wide[NUMBER_WIDTH-1:0];
  end

endmodule

FILE: rtl/lkp_parser.sv
// Per-string parse state and the combinational step that consumes one character.
module lkp_parser #(
  parameter int NUMBER_WIDTH = lkp_pkg::NUMBER_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  logic [7:0]           char_q,
  input  logic [3:0]           mask,
  output lkp_pkg::lkp_result_t result
);
  import lkp_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE, PH_D_E, PH_D_V, PH_COLON, PH_F_U, PH_F_N, PH_F_C, PH_B_U,
    PH_B_S, PH_R_E, PH_R_G, PH_AFTER_COLON, PH_ZERO, PH_HEXPFX, PH_DIGITS, PH_DROP
  } phase_t;

  phase_t                  phase, phase_next;
  logic [1:0]              idx, idx_next;
  logic [3:0]              seen, seen_next, seen_eff;
  radix_t                  radix, radix_next;
  logic [NUMBER_WIDTH-1:0] values [4];

  logic [7:0]              c;
  logic [4:0]              hv;
  logic                    commit, do_idle, fin, fin_chk, fin_ok, clear;
  logic                    wr_en;
  logic [NUMBER_WIDTH-1:0] wr_val;
  logic                    digit_ok;
  logic [NUMBER_WIDTH-1:0] acc_next;
  logic                    kw_hit;
  logic [1:0]              kw_idx;
  phase_t                  kw_phase;

  lkp_accum #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_accum (
    .c        (c),
    .radix    (radix),
    .acc      (values[idx]),
    .digit_ok (digit_ok),
    .acc_next (acc_next)
  );

  always_comb begin
    c  = upcase(char_q);
    hv = hex_value(c);

    kw_hit   = 1'b1;
    kw_idx   = 2'd0;
    kw_phase = PH_D_E;
    case (c)
      CH_D: begin
        kw_idx   = 2'd0;
        kw_phase = PH_D_E;
      end
      CH_F: begin
        kw_idx   = 2'd1;
        kw_phase = PH_F_U;
      end
      CH_B: begin
        kw_idx   = 2'd2;
        kw_phase = PH_B_U;
      end
      CH_R: begin
        kw_idx   = 2'd3;
        kw_phase = PH_R_E;
      end
      default: kw_hit = 1'b0;
    endcase

    phase_next = phase;
    idx_next   = idx;
    seen_next  = seen;
    radix_next = radix;
    wr_en      = 1'b0;
    wr_val     = NUMBER_WIDTH'(hv[3:0]);
    commit     = 1'b0;
    do_idle    = 1'b0;
    fin        = 1'b0;
    fin_chk    = 1'b0;
    clear      = 1'b0;

    case (phase)
      PH_IDLE: do_idle = 1'b1;
      PH_D_E: if (c == CH_E) phase_next = PH_D_V; else fin = 1'b1;
      PH_D_V: if (c == CH_V) phase_next = PH_COLON; else fin = 1'b1;
      PH_COLON: if (c == CH_COLON) phase_next = PH_AFTER_COLON; else fin = 1'b1;
      PH_F_U: if (c == CH_U) phase_next = PH_F_N; else fin = 1'b1;
      PH_F_N: if (c == CH_N) phase_next = PH_F_C; else fin = 1'b1;
      PH_F_C: if (c == CH_C) phase_next = PH_COLON; else fin = 1'b1;
      PH_B_U: if (c == CH_U) phase_next = PH_B_S; else fin = 1'b1;
      PH_B_S: if (c == CH_S) phase_next = PH_COLON; else fin = 1'b1;
      PH_R_E: if (c == CH_E) phase_next = PH_R_G; else fin = 1'b1;
      PH_R_G: if (c == CH_G) phase_next = PH_COLON; else fin = 1'b1;
      PH_AFTER_COLON: begin
        if (c inside {[CH_0:CH_9]}) begin
          wr_en      = 1'b1;
          radix_next = RADIX_DEC;
          phase_next = (c == CH_0) ? PH_ZERO : PH_DIGITS;
        end else if (!(c == CH_SPACE || c == CH_TAB)) begin
          fin     = 1'b1;
          fin_chk = 1'b1;
        end
      end
      PH_ZERO: begin
        if (c == CH_X) begin
          phase_next = PH_HEXPFX;
        end else if (c inside {[CH_0:CH_7]}) begin
          wr_en      = 1'b1;
          radix_next = RADIX_OCT;
          phase_next = PH_DIGITS;
        end else begin
          commit  = 1'b1;
          do_idle = 1'b1;
        end
      end
      PH_HEXPFX: begin
        if (!hv[4]) begin
          wr_en      = 1'b1;
          radix_next = RADIX_HEX;
          phase_next = PH_DIGITS;
        end else begin
          commit  = 1'b1;
          fin     = 1'b1;
          fin_chk = 1'b1;
        end
      end
      PH_DIGITS: begin
        if (digit_ok) begin
          wr_en  = 1'b1;
          wr_val = acc_next;
        end else begin
          commit  = 1'b1;
          do_idle = 1'b1;
        end
      end
      PH_DROP: if (char_q == CH_NUL) clear = 1'b1;
      default: clear = 1'b1;
    endcase

    seen_eff = commit ? (seen | (4'b0001 << idx)) : seen;
    if (commit) begin
      seen_next  = seen_eff;
      phase_next = PH_IDLE;
    end

    if (do_idle) begin
      if (kw_hit) begin
        if (seen_eff[kw_idx]) begin
          fin = 1'b1;
        end else begin
          idx_next   = kw_idx;
          phase_next = kw_phase;
        end
      end else if (!(c == CH_SPACE || c == CH_TAB)) begin
        fin     = 1'b1;
        fin_chk = 1'b1;
      end
    end

    fin_ok = fin_chk && ((mask & ~seen_eff) == 4'b0000);

    if (fin) begin
      if (char_q == CH_NUL) clear = 1'b1;
      else phase_next = PH_DROP;
    end

    result.emit           = fin;
    result.ok             = fin_ok;
    result.device_value   = fin_ok ? OUT_W'(values[0]) : '0;
    result.function_value = fin_ok ? OUT_W'(values[1]) : '0;
    result.bus_value      = fin_ok ? OUT_W'(values[2]) : '0;
    result.register_value = fin_ok ? OUT_W'(values[3]) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst || (advance && clear)) begin
      phase  <= PH_IDLE;
      idx    <= 2'd0;
      seen   <= 4'b0000;
      radix  <= RADIX_DEC;
      values <= '{default: '0};
    end else if (advance) begin
      phase <= phase_next;
      idx   <= idx_next;
      seen  <= seen_next;
      radix <= radix_next;
      if (wr_en) values[idx] <= wr_val;
    end
  end

endmodule

FILE: rtl/location_keyword_parser_unit.sv
// Top level of the location keyword parser: input register, parser and result register.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+------------------------------------------
//   input    | in_valid / in_stall       | char_in
//   result   | out_valid / out_stall     | ok, device_value, function_value,
//            |                           | bus_value, register_value
//   config   | cfg_valid / cfg_ready     | required_mask
//
// One character per cycle unless the result stalls: an accepted item is parsed while it
// sits in the input register, and its result, if any, is captured by the result register.
// The parser advances only when the result register is empty or being taken, so a
// stalled result stops the input register and in turn raises in_stall.
// Reset clears the parse state, empties both registers and sets the stored mask to 15.
module location_keyword_parser_unit #(
  parameter int NUMBER_WIDTH = lkp_pkg::NUMBER_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                char_in,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      ok,
  output logic [lkp_pkg::OUT_W-1:0] device_value,
  output logic [lkp_pkg::OUT_W-1:0] function_value,
  output logic [lkp_pkg::OUT_W-1:0] bus_value,
  output logic [lkp_pkg::OUT_W-1:0] register_value,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [3:0]                required_mask
);
  import lkp_pkg::*;

  logic        q_valid;
  logic [7:0]  char_q;
  logic [3:0]  mask;
  logic        advance;
  logic        accept;
  lkp_result_t result;

  assign advance   = q_valid && (!out_valid || !out_stall);
  assign in_stall  = q_valid && !advance;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= 4'hF;
    end else if (cfg_valid && cfg_ready) begin
      mask <= required_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (accept) begin
      q_valid <= 1'b1;
    end else if (advance) begin
      q_valid <= 1'b0;
    end
    if (accept) char_q <= char_in;
  end

  lkp_parser #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_parser (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .char_q  (char_q),
    .mask    (mask),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && result.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (advance && result.emit) begin
      ok             <= result.ok;
      device_value   <= result.device_value;
      function_value <= result.function_value;
      bus_value      <= result.bus_value;
      register_value <= result.register_value;
    end
  end

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> q_valid)
    else $error("Input stalled with no item held.");

  a_held_item_stable: assert property (@(posedge clk) disable iff (rst)
    (q_valid && !advance) |=> (q_valid && $stable(char_q)))
    else $error("Held item changed before it was parsed.");

  a_fail_values_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !ok) |-> (device_value == '0 && function_value == '0 &&
                            bus_value == '0 && register_value == '0))
    else $error("Failed result carries nonzero values.");

endmodule

FILE: tb/sv/location_keyword_parser_unit_test.sv
// Testbench for location_keyword_parser_unit with a parse predictor and a result checker.
module location_keyword_parser_unit_test;
  import lkp_pkg::*;

  localparam int NUMBER_WIDTH = NUMBER_WIDTH_DEF;
  localparam longint unsigned VALUE_MAX = {64{1'b1}} >> (64 - NUMBER_WIDTH);
  localparam int RESULT_HOLD_CYCLES = 200;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 4;

  localparam int FIELD_DEVICE = 0;
  localparam int FIELD_FUNCTION = 1;
  localparam int FIELD_BUS = 2;
  localparam int FIELD_REGISTER = 3;

  localparam int MODE_RECEIVER_BUSY = 0;
  localparam int MODE_SENDER_BUSY = 1;
  localparam int MODE_NO_IDLE = 2;

  typedef enum logic [4:0] {
    P_IDLE, P_D_E, P_D_V, P_COLON, P_F_U, P_F_N, P_F_C, P_B_U, P_B_S, P_R_E, P_R_G,
    P_AFTER_COLON, P_ZERO, P_HEX_PREFIX, P_DIGITS, P_DROP
  } parse_phase_t;

  typedef struct packed {
    logic             ok;
    logic [OUT_W-1:0] device_value;
    logic [OUT_W-1:0] function_value;
    logic [OUT_W-1:0] bus_value;
    logic [OUT_W-1:0] register_value;
  } location_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] char_in = 8'h00;
  logic out_valid;
  logic out_stall = 1'b0;
  logic ok;
  logic [OUT_W-1:0] device_value;
  logic [OUT_W-1:0] function_value;
  logic [OUT_W-1:0] bus_value;
  logic [OUT_W-1:0] register_value;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [3:0] required_mask = 4'hF;

  location_keyword_parser_unit #(.NUMBER_WIDTH(NUMBER_WIDTH)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .char_in(char_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .ok(ok),
    .device_value(device_value),
    .function_value(function_value),
    .bus_value(bus_value),
    .register_value(register_value),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .required_mask(required_mask)
  );

  always #5 clk = ~clk;

  parse_phase_t pstate;
  logic [1:0] field_sel;
  longint unsigned field_val [4];
  logic [3:0] field_seen;
  radix_t num_radix;
  logic [3:0] required_fields;
  location_t loc_result;

  location_t expected_locations [$];
  location_t got_location;
  logic [7:0] text_buf [$];
  string keyword_text [4] = '{"DEV:", "FUNC:", "BUS:", "REG:"};

  int idle_mode = MODE_NO_IDLE;
  int holds_asked = 0;
  int holds_served = 0;
  int hold_left = 0;
  int chars_sent = 0;
  int error_count = 0;
  int quiet_cycles = 0;

  function automatic logic [7:0] fold_case(logic [7:0] c);
    if (c >= CH_LOW_A && c <= CH_LOW_Z) return c - CASE_OFFSET;
    return c;
  endfunction

  function automatic int unsigned digit_of(logic [7:0] c);
    if (c >= CH_0 && c <= CH_9) return c - CH_0;
    if (c >= CH_A && c <= CH_F) return c - CH_A + 10;
    return 16;
  endfunction

  function automatic void clear_string();
    pstate = P_IDLE;
    field_sel = 2'(FIELD_DEVICE);
    for (int i = 0; i < 4; i++) field_val[i] = 0;
    field_seen = '0;
    num_radix = RADIX_DEC;
  endfunction

  function automatic bit mask_met();
    return (required_fields & ~field_seen) == 4'h0;
  endfunction

  function automatic bit close_string(bit good, logic [7:0] raw);
    loc_result.ok = good;
    loc_result.device_value = good ? OUT_W'(field_val[FIELD_DEVICE]) : '0;
    loc_result.function_value = good ? OUT_W'(field_val[FIELD_FUNCTION]) : '0;
    loc_result.bus_value = good ? OUT_W'(field_val[FIELD_BUS]) : '0;
    loc_result.register_value = good ? OUT_W'(field_val[FIELD_REGISTER]) : '0;
    if (raw == CH_NUL) clear_string();
    else pstate = P_DROP;
    return 1'b1;
  endfunction

  function automatic void end_number();
    field_seen[field_sel] = 1'b1;
    pstate = P_IDLE;
  endfunction

  function automatic bit start_keyword(logic [7:0] c, logic [7:0] raw);
    logic [1:0] idx;
    parse_phase_t ph;
    case (c)
      CH_D: begin
        idx = 2'(FIELD_DEVICE);
        ph = P_D_E;
      end
      CH_F: begin
        idx = 2'(FIELD_FUNCTION);
        ph = P_F_U;
      end
      CH_B: begin
        idx = 2'(FIELD_BUS);
        ph = P_B_U;
      end
      CH_R: begin
        idx = 2'(FIELD_REGISTER);
        ph = P_R_E;
      end
      CH_SPACE, CH_TAB: return 1'b0;
      default: return close_string(mask_met(), raw);
    endcase
    if (field_seen[idx]) return close_string(1'b0, raw);
    field_sel = idx;
    pstate = ph;
    return 1'b0;
  endfunction

  // Returns 1 when the character decides the string; the result is then in loc_result.
  function automatic bit parse_location_char(logic [7:0] raw);
    logic [7:0] c;
    int unsigned d;
    int unsigned base;
    logic [7:0] want;
    parse_phase_t nxt;
    c = fold_case(raw);
    d = digit_of(c);
    case (pstate)
      P_IDLE: return start_keyword(c, raw);
      P_D_E, P_D_V, P_COLON, P_F_U, P_F_N, P_F_C, P_B_U, P_B_S, P_R_E, P_R_G: begin
        case (pstate)
          P_D_E: begin want = CH_E; nxt = P_D_V; end
          P_D_V: begin want = CH_V; nxt = P_COLON; end
          P_F_U: begin want = CH_U; nxt = P_F_N; end
          P_F_N: begin want = CH_N; nxt = P_F_C; end
          P_F_C: begin want = CH_C; nxt = P_COLON; end
          P_B_U: begin want = CH_U; nxt = P_B_S; end
          P_B_S: begin want = CH_S; nxt = P_COLON; end
          P_R_E: begin want = CH_E; nxt = P_R_G; end
          P_R_G: begin want = CH_G; nxt = P_COLON; end
          default: begin want = CH_COLON; nxt = P_AFTER_COLON; end
        endcase
        if (c == want) begin
          pstate = nxt;
          return 1'b0;
        end
        return close_string(1'b0, raw);
      end
      P_AFTER_COLON: begin
        if (c == CH_SPACE || c == CH_TAB) return 1'b0;
        if (d < 10) begin
          field_val[field_sel] = d;
          num_radix = RADIX_DEC;
          pstate = (c == CH_0) ? P_ZERO : P_DIGITS;
          return 1'b0;
        end
        return close_string(mask_met(), raw);
      end
      P_ZERO: begin
        if (c == CH_X) begin
          pstate = P_HEX_PREFIX;
          return 1'b0;
        end
        if (d < 8) begin
          field_val[field_sel] = d;
          num_radix = RADIX_OCT;
          pstate = P_DIGITS;
          return 1'b0;
        end
        end_number();
        return start_keyword(c, raw);
      end
      P_HEX_PREFIX: begin
        if (d < 16) begin
          field_val[field_sel] = d;
          num_radix = RADIX_HEX;
          pstate = P_DIGITS;
          return 1'b0;
        end
        end_number();
        return close_string(mask_met(), raw);
      end
      P_DIGITS: begin
        base = (num_radix == RADIX_HEX) ? 16 : (num_radix == RADIX_OCT) ? 8 : 10;
        if (d < base) begin
          if (field_val[field_sel] > (VALUE_MAX - d) / base) field_val[field_sel] = VALUE_MAX;
          else field_val[field_sel] = field_val[field_sel] * base + d;
          return 1'b0;
        end
        end_number();
        return start_keyword(c, raw);
      end
      P_DROP: begin
        if (raw == CH_NUL) clear_string();
        return 1'b0;
      end
      default: begin
        clear_string();
        return 1'b0;
      end
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      clear_string();
      required_fields = 4'hF;
    end else begin
      if (cfg_valid && cfg_ready) required_fields = required_mask;
      if (in_valid && !in_stall) begin
        if (parse_location_char(char_in)) expected_locations.push_back(loc_result);
      end
    end
  end

  function automatic void compare_field(string name, logic [OUT_W-1:0] want,
                                        logic [OUT_W-1:0] got);
    if (want !== got) begin
      $display("%0t %s: expected %0h, actual %0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_locations.size() == 0) begin
        $display("%0t unexpected result: expected none, actual ok %0b values %0h %0h %0h %0h",
                 $time, ok, device_value, function_value, bus_value, register_value);
        error_count++;
      end else begin
        got_location = expected_locations.pop_front();
        compare_field("ok", OUT_W'(got_location.ok), OUT_W'(ok));
        compare_field("device_value", got_location.device_value, device_value);
        compare_field("function_value", got_location.function_value, function_value);
        compare_field("bus_value", got_location.bus_value, bus_value);
        compare_field("register_value", got_location.register_value, register_value);
      end
    end
  end

  function automatic bit sender_idles();
    if (idle_mode == MODE_RECEIVER_BUSY) return $urandom_range(99) < 11;
    if (idle_mode == MODE_SENDER_BUSY) return $urandom_range(99) < 66;
    return 1'b0;
  endfunction

  function automatic bit receiver_idles();
    if (idle_mode == MODE_RECEIVER_BUSY) return $urandom_range(99) < 66;
    if (idle_mode == MODE_SENDER_BUSY) return $urandom_range(99) < 11;
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    if (holds_served != holds_asked) begin
      hold_left = RESULT_HOLD_CYCLES;
      holds_served = holds_asked;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= receiver_idles();
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("location_keyword_parser_unit: mismatch");
        $finish;
      end
    end
  end

  task automatic send_char(logic [7:0] c);
    while (sender_idles()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    char_in <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_text();
    for (int i = 0; i < text_buf.size(); i++) send_char(text_buf[i]);
    text_buf.delete();
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_locations.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mask(logic [3:0] mask);
    wait_drained();
    cfg_valid <= 1'b1;
    required_mask <= mask;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic void put(logic [7:0] c);
    text_buf.push_back(c);
  endfunction

  function automatic logic [7:0] letter_case(logic [7:0] c);
    return $urandom_range(1) ? c + CASE_OFFSET : c;
  endfunction

  function automatic logic [7:0] hex_char();
    int v;
    v = $urandom_range(15);
    if (v < 10) return 8'(CH_0 + v);
    return letter_case(8'(CH_A + v - 10));
  endfunction

  function automatic void put_blanks();
    if ($urandom_range(1) == 0) begin
      repeat ($urandom_range(1, 2)) put($urandom_range(1) ? CH_SPACE : CH_TAB);
    end
  endfunction

  function automatic void put_keyword(int idx, bit broken);
    string s;
    int bad;
    logic [7:0] c;
    s = keyword_text[idx];
    bad = broken ? $urandom_range(s.len() - 1, 1) : 0;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (broken && i == bad) c = 8'(c + $urandom_range(1, 5));
      else if (c != CH_COLON) c = letter_case(c);
      put(c);
    end
  endfunction

  function automatic void put_number();
    int kind;
    int count;
    kind = $urandom_range(9);
    count = ($urandom_range(7) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 3);
    if (kind <= 3) begin
      put(8'(CH_0 + $urandom_range(1, 9)));
      repeat (count - 1) put(8'(CH_0 + $urandom_range(9)));
    end else if (kind <= 5) begin
      put(CH_0);
      repeat (count - 1) put(8'(CH_0 + $urandom_range(7)));
      if ($urandom_range(3) == 0) put(8'(CH_0 + $urandom_range(8, 9)));
    end else if (kind <= 8) begin
      put(CH_0);
      put(letter_case(CH_X));
      if ($urandom_range(9) != 0) repeat (count) put(hex_char());
    end else begin
      put(CH_0);
    end
  endfunction

  function automatic void make_location();
    int order [4];
    int tmp;
    int j;
    int noise;
    int broken_at;
    int last_field;
    noise = $urandom_range(15);
    broken_at = $urandom_range(3);
    last_field = FIELD_DEVICE;
    for (int i = 0; i < 4; i++) order[i] = i;
    for (int i = 3; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    if (noise != 3) begin
      put_blanks();
      for (int i = 0; i < 4; i++) begin
        if (i == 0 || $urandom_range(3) != 0) begin
          put_keyword(order[i], noise == 1 && i == broken_at);
          put_blanks();
          put_number();
          put_blanks();
          last_field = order[i];
        end
      end
      if (noise == 0) put_keyword(last_field, 1'b0);
    end
    if (noise == 2 || noise == 3) repeat ($urandom_range(1, 4)) put(8'($urandom_range(255)));
    put(CH_NUL);
  endfunction

  task automatic send_word(string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
    put(CH_NUL);
    send_text();
  endtask

  task automatic test_directed_strings();
    idle_mode = MODE_RECEIVER_BUSY;
    send_word("dEv:\t9");
    send_word("DX");
    send_word("B:1b");
    send_word("R:0xZ");
    send_word("F:078");
    send_word("\377");
  endtask

  task automatic test_result_backpressure();
    idle_mode = MODE_NO_IDLE;
    holds_asked++;
    repeat (8) begin
      make_location();
      send_text();
    end
  endtask

  task automatic test_random_locations(int mode, logic [3:0] first_mask, int n_chars);
    int start;
    int strings;
    idle_mode = mode;
    write_mask(first_mask);
    start = chars_sent;
    strings = 0;
    while (chars_sent - start < n_chars) begin
      make_location();
      send_text();
      strings++;
      if (strings % 12 == 0) write_mask(4'($urandom_range(15)));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed_strings();
    test_result_backpressure();
    test_random_locations(MODE_RECEIVER_BUSY, 4'h0, 280);
    test_random_locations(MODE_SENDER_BUSY, 4'hF, 280);
    test_random_locations(MODE_NO_IDLE, 4'($urandom_range(15)), 270);
    in_valid <= 1'b0;
    while (expected_locations.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("location_keyword_parser_unit: match");
    end else begin
      $display("location_keyword_parser_unit: mismatch");
    end
    $finish;
  end

endmodule
